>>> rtl/core/adaptive_three_line_chroma_comb_core_macros.svh
// Assertion macros for the adaptive three-line chroma comb core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef ADAPTIVE_THREE_LINE_CHROMA_COMB_CORE_MACROS_SVH
`define ADAPTIVE_THREE_LINE_CHROMA_COMB_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ATLCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATLCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ATLCC_ASSERT(lbl, clk, rst, prop, msg)
`define ATLCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

>>> rtl/core/atlcc_pkg.sv
// Shared constants and types of the adaptive three-line chroma comb core.
// No dependencies.
package atlcc_pkg;

  localparam int LINE_WIDTH = 1024;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int CFG_COL_W  = 10;
  localparam int CMP_W      = (COL_W > CFG_COL_W) ? COL_W : CFG_COL_W;
  localparam int SAMPLE_W   = 16;
  localparam int CHROMA_W   = 18;
  localparam int KR_W       = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_RANGE      = 2'd2;

  localparam logic [CFG_COL_W-1:0] ACTIVE_START_RST = 10'd134;
  localparam logic [CFG_COL_W-1:0] ACTIVE_END_RST   = 10'd894;
  localparam logic [KR_W-1:0]      K_RANGE_RST      = 18'd64440;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // divider: quotient bits and operand width
  localparam int Q_W   = 18;
  localparam int DIV_W = 22;
  localparam int QCNT_W = $clog2(Q_W + 1);

  typedef struct packed {
    logic signed [CHROMA_W-1:0] c;
    logic signed [CHROMA_W-1:0] c1;
    logic signed [CHROMA_W-1:0] p;
    logic signed [CHROMA_W-1:0] p1;
    logic signed [CHROMA_W-1:0] n;
    logic signed [CHROMA_W-1:0] n1;
    logic                       last;
  } opnd_t;

endpackage

>>> rtl/core/atlcc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module atlcc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/atlcc_fifo.sv
// Short operand queue between the line-store front end and the comb back end.
// Depends on atlcc_pkg and the assertion macros.
`include "adaptive_three_line_chroma_comb_core_macros.svh"
module atlcc_fifo import atlcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  opnd_t              push_data,
  input  logic               pop,
  output opnd_t              pop_data,
  output logic               empty,
  output logic [FIFO_CW-1:0] count
);

  opnd_t              slot [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic               full;

  assign empty    = (count == '0);
  assign full     = (count == FIFO_CW'(FIFO_DEPTH));
  assign pop_data = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ATLCC_ASSERT(a_fifo_no_overflow, clk, rst, !(push && full && !pop), "queue overflow")
  `ATLCC_ASSERT(a_fifo_no_underflow, clk, rst, !(pop && empty), "queue underflow")

endmodule

>>> rtl/core/atlcc_div.sv
// Radix-2 restoring divider: quo = floor(num * 2^Q_W / den), num < den.
// Depends on atlcc_pkg and the assertion macros.
`include "adaptive_three_line_chroma_comb_core_macros.svh"
module atlcc_div import atlcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  den_r;
  logic [QCNT_W-1:0] cnt;
  logic [DIV_W:0]    rem2;
  logic              ge;

  assign busy = (cnt != '0);
  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? DIV_W'(rem2 - {1'b0, den_r}) : rem2[DIV_W-1:0];
      quo <= {quo[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == QCNT_W'(1));
      if (start) begin
        cnt <= QCNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ATLCC_ASSERT_NEXT(a_div_start_busy, clk, rst, start, busy, "divider not busy after start")

endmodule

>>> rtl/core/atlcc_front.sv
// Front end: sample window, 1D bandpass, line stores, flags and left registers.
// Depends on atlcc_pkg, atlcc_ram and the assertion macros.
`include "adaptive_three_line_chroma_comb_core_macros.svh"
module atlcc_front import atlcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 line_start,
  input  logic                 line_active,
  input  logic [CFG_COL_W-1:0] active_start,
  input  logic [CFG_COL_W-1:0] active_end,
  input  logic [FIFO_CW-1:0]   fifo_count,
  output logic                 push,
  output opnd_t                push_data
);

  logic [SAMPLE_W-1:0] win [4];
  logic [COL_W-1:0]    col;
  logic                mid_act;
  logic                abv_act;
  logic                bel_act;

  logic                in_acc;
  logic [COL_W-1:0]    col_eff;
  logic                has_h;
  logic [COL_W-1:0]    h;
  logic                act;
  logic                mid_eff;
  logic                abv_eff;
  logic                bel_eff;
  logic signed [CHROMA_W:0]   bsum;
  logic signed [CHROMA_W-1:0] b_new;
  logic [CMP_W:0]      h_ext;

  logic                s1_v;
  logic                s1_clr;
  logic                s1_hh;
  logic                s1_act;
  logic                s1_mid;
  logic                s1_abv;
  logic                s1_last;
  logic [COL_W-1:0]    s1_h;
  logic signed [CHROMA_W-1:0] s1_b;

  logic [CHROMA_W-1:0] mid_rd;
  logic [CHROMA_W-1:0] abv_rd;
  logic signed [CHROMA_W-1:0] m_val;
  logic signed [CHROMA_W-1:0] a_val;
  logic signed [CHROMA_W-1:0] left_m;
  logic signed [CHROMA_W-1:0] left_a;
  logic signed [CHROMA_W-1:0] left_b;

  logic                re;
  logic                we;

  assign push     = s1_v && s1_act && s1_mid;
  assign in_ready = (fifo_count + FIFO_CW'(push)) < FIFO_CW'(FIFO_DEPTH);
  assign in_acc   = in_valid && in_ready;

  assign col_eff = line_start ? '0 : col;
  assign has_h   = (col_eff >= COL_W'(2));
  assign h       = col_eff - COL_W'(2);
  assign h_ext   = (CMP_W + 1)'(h);
  assign act     = has_h && (h_ext >= (CMP_W + 1)'(active_start))
                   && (h_ext < (CMP_W + 1)'(active_end));
  assign bel_eff = line_start ? line_active : bel_act;
  assign mid_eff = line_start ? bel_act : mid_act;
  assign abv_eff = line_start ? mid_act : abv_act;

  assign bsum  = $signed({2'b00, win[1], 1'b0}) - $signed({3'b000, win[3]})
                 - $signed({3'b000, sample});
  assign b_new = (act && bel_eff) ? bsum[CHROMA_W-1:0] : '0;

  assign re = in_acc && has_h;
  assign we = s1_v && s1_hh;

  atlcc_ram #(.WIDTH(CHROMA_W), .DEPTH(LINE_WIDTH)) u_mid_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_h),
    .wdata (s1_b),
    .re    (re),
    .raddr (h),
    .rdata (mid_rd)
  );

  atlcc_ram #(.WIDTH(CHROMA_W), .DEPTH(LINE_WIDTH)) u_abv_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_h),
    .wdata (m_val),
    .re    (re),
    .raddr (h),
    .rdata (abv_rd)
  );

  assign m_val = s1_act ? $signed(mid_rd) : '0;
  assign a_val = (s1_act && s1_abv) ? $signed(abv_rd) : '0;

  always_comb begin
    push_data.c    = m_val;
    push_data.c1   = left_m;
    push_data.p    = a_val;
    push_data.p1   = left_a;
    push_data.n    = s1_b;
    push_data.n1   = left_b;
    push_data.last = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      mid_act <= 1'b0;
      abv_act <= 1'b0;
      bel_act <= 1'b0;
      s1_v    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win[i] <= '0;
      end
    end else begin
      s1_v <= in_acc;
      if (in_acc) begin
        abv_act <= abv_eff;
        mid_act <= mid_eff;
        bel_act <= bel_eff;
        col     <= (col_eff == COL_W'(LINE_WIDTH - 1)) ? '0 : col_eff + 1'b1;
        win[0]  <= sample;
        win[1]  <= win[0];
        win[2]  <= win[1];
        win[3]  <= win[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_clr  <= line_start;
      s1_hh   <= has_h;
      s1_act  <= act;
      s1_mid  <= mid_eff;
      s1_abv  <= abv_eff;
      s1_h    <= h;
      s1_b    <= b_new;
      s1_last <= ((h_ext + 1'b1) == (CMP_W + 1)'(active_end));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_m <= '0;
      left_a <= '0;
      left_b <= '0;
    end else if (s1_v) begin
      if (s1_hh) begin
        left_m <= m_val;
        left_a <= a_val;
        left_b <= s1_b;
      end else if (s1_clr) begin
        left_m <= '0;
        left_a <= '0;
        left_b <= '0;
      end
    end
  end

  `ATLCC_ASSERT(a_store_no_collision, clk, rst, !(re && we && (h == s1_h)), "store read hits pending write")

endmodule

>>> rtl/core/atlcc_back.sv
// Back end: similarity weights, normalisation and weighted sum for one item.
// Depends on atlcc_pkg, atlcc_div and the assertion macros.
`include "adaptive_three_line_chroma_comb_core_macros.svh"
module atlcc_back import atlcc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fifo_empty,
  input  opnd_t                      fifo_data,
  output logic                       pop,
  input  logic [KR_W-1:0]            k_range,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [CHROMA_W-1:0] chroma,
  output logic                       last
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIST = 4'd1;
  localparam logic [3:0] ST_KP   = 4'd2;
  localparam logic [3:0] ST_KPW  = 4'd3;
  localparam logic [3:0] ST_KN   = 4'd4;
  localparam logic [3:0] ST_KNW  = 4'd5;
  localparam logic [3:0] ST_ADJ  = 4'd6;
  localparam logic [3:0] ST_SCW  = 4'd7;
  localparam logic [3:0] ST_MUL1 = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_MUL3 = 4'd10;
  localparam logic [3:0] ST_MUL4 = 4'd11;
  localparam logic [3:0] ST_ACC  = 4'd12;
  localparam logic [3:0] ST_RND  = 4'd13;

  localparam logic [16:0] K_ONE  = 17'd65536;
  localparam logic [17:0] SC_ONE = 18'd65536;
  localparam logic [17:0] SC_MAX = 18'd262143;

  function automatic logic [17:0] mag(input logic signed [17:0] v);
    logic [18:0] t;
    t = v[17] ? 19'(-$signed({v[17], v})) : 19'({v[17], v});
    return t[17:0];
  endfunction

  function automatic logic [17:0] adiff(input logic [17:0] a, input logic [17:0] b);
    return (a >= b) ? 18'(a - b) : 18'(b - a);
  endfunction

  function automatic logic signed [22:0] nbr_dist(input logic signed [17:0] c,
      input logic signed [17:0] c1, input logic signed [17:0] x,
      input logic signed [17:0] x1);
    logic [18:0] s;
    logic [21:0] ten;
    logic [18:0] sub;
    s   = 19'(adiff(mag(c), mag(x))) + 19'(adiff(mag(c1), mag(x1)));
    ten = (22'(s) << 3) + (22'(s) << 1);
    sub = 19'(mag(c)) + 19'(mag(x1));
    return $signed({1'b0, ten}) - $signed({4'b0000, sub});
  endfunction

  logic [3:0]          st;
  opnd_t               op;
  logic signed [22:0]  dp;
  logic signed [22:0]  dn;
  logic signed [20:0]  tf;
  logic [21:0]         rr;
  logic [16:0]         kp;
  logic [16:0]         kn;
  logic [17:0]         sc;
  logic signed [36:0]  t1;
  logic signed [36:0]  e;
  logic [35:0]         lo;
  logic signed [37:0]  hi;
  logic signed [55:0]  acc;

  logic                div_start;
  logic [DIV_W-1:0]    div_num;
  logic [DIV_W-1:0]    div_den;
  logic                div_busy;
  logic                div_done;
  logic [Q_W-1:0]      div_q;

  logic signed [22:0]  dsel;
  logic                d_le0;
  logic                d_ger;
  logic [16:0]         kp_a;
  logic [16:0]         kn_a;
  logic [17:0]         ksum;
  logic [17:0]         krx;
  logic [18:0]         pn_abs;
  logic signed [18:0]  pn_sum;
  logic [19:0]         five;
  logic                neg;
  logic [55:0]         amag;
  logic [55:0]         rsum;
  logic [23:0]         rq;
  logic signed [CHROMA_W-1:0] res;
  logic                out_free;

  assign pop      = (st == ST_IDLE) && !fifo_empty;
  assign out_free = !out_valid || out_ready;

  assign dsel  = (st == ST_KP) ? dp : dn;
  assign d_le0 = dsel[22] || (dsel == '0);
  assign d_ger = (dsel >= $signed({1'b0, rr}));

  always_comb begin
    kp_a = kp;
    kn_a = kn;
    if ({2'b00, kn} > 19'(kp) * 19'd3) begin
      kp_a = '0;
    end else if ({2'b00, kp} > 19'(kn) * 19'd3) begin
      kn_a = '0;
    end
  end
  assign ksum = 18'(kp_a) + 18'(kn_a);

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_W'(rr - 22'(dsel[21:0]));
    div_den   = rr;
    unique case (st)
      ST_KP, ST_KN: div_start = !d_le0 && !d_ger;
      ST_ADJ: begin
        div_num   = DIV_W'(1 << 15);
        div_den   = DIV_W'(ksum);
        div_start = ((kp != '0) || (kn != '0)) && (ksum > 18'd32768);
      end
      default: div_start = 1'b0;
    endcase
  end

  atlcc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign krx    = (k_range == '0) ? 18'd1 : k_range;
  assign pn_sum = 19'(op.p) + 19'(op.n);
  assign pn_abs = pn_sum[18] ? 19'(-pn_sum) : 19'(pn_sum);
  assign five   = (20'(adiff(mag(op.p), mag(op.n))) << 2) + 20'(adiff(mag(op.p), mag(op.n)));

  assign neg  = acc[55];
  assign amag = neg ? 56'(-acc) : 56'(acc);
  assign rsum = amag + (56'(1) << 31);
  assign rq   = rsum[55:32];

  always_comb begin
    if (neg) begin
      res = (rq > 24'd131072) ? CHROMA_W'(-131072) : CHROMA_W'(-$signed({1'b0, rq}));
    end else begin
      res = (rq > 24'd131071) ? CHROMA_W'(131071) : rq[CHROMA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= fifo_data;
    end
    unique case (st)
      ST_DIST: begin
        dp <= nbr_dist(op.c, op.c1, op.p, op.p1);
        dn <= nbr_dist(op.c, op.c1, op.n, op.n1);
        tf <= $signed({1'b0, five}) - $signed({2'b00, pn_abs});
        rr <= (22'(krx) << 3) + (22'(krx) << 1);
      end
      ST_KP: kp <= d_le0 ? K_ONE : '0;
      ST_KPW: if (div_done) kp <= {1'b0, div_q[Q_W-1:2]};
      ST_KN: kn <= d_le0 ? K_ONE : '0;
      ST_KNW: if (div_done) kn <= {1'b0, div_q[Q_W-1:2]};
      ST_ADJ: begin
        if ((kp != '0) || (kn != '0)) begin
          kp <= kp_a;
          kn <= kn_a;
          sc <= SC_MAX;
        end else begin
          if (tf[20] || (tf == '0)) begin
            kp <= K_ONE;
            kn <= K_ONE;
          end
          sc <= SC_ONE;
        end
      end
      ST_SCW: if (div_done) sc <= div_q;
      ST_MUL1: t1 <= (op.c - op.p) * $signed({1'b0, kp});
      ST_MUL2: e <= t1 + (op.c - op.n) * $signed({1'b0, kn});
      ST_MUL3: lo <= e[17:0] * sc;
      ST_MUL4: hi <= $signed(e[36:18]) * $signed({1'b0, sc});
      ST_ACC: acc <= $signed({hi, 18'b0}) + $signed({20'b0, lo});
      default: ;
    endcase
    if ((st == ST_RND) && out_free) begin
      chroma <= res;
      last   <= op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: if (!fifo_empty) st <= ST_DIST;
        ST_DIST: st <= ST_KP;
        ST_KP:   st <= div_start ? ST_KPW : ST_KN;
        ST_KPW:  if (div_done) st <= ST_KN;
        ST_KN:   st <= div_start ? ST_KNW : ST_ADJ;
        ST_KNW:  if (div_done) st <= ST_ADJ;
        ST_ADJ:  st <= div_start ? ST_SCW : ST_MUL1;
        ST_SCW:  if (div_done) st <= ST_MUL1;
        ST_MUL1: st <= ST_MUL2;
        ST_MUL2: st <= ST_MUL3;
        ST_MUL3: st <= ST_MUL4;
        ST_MUL4: st <= ST_ACC;
        ST_ACC:  st <= ST_RND;
        ST_RND: begin
          if (out_free) begin
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `ATLCC_ASSERT(a_back_div_free, clk, rst, !(div_start && div_busy), "divider restarted while busy")

endmodule

>>> rtl/core/adaptive_three_line_chroma_comb_core.sv
// Top level of the adaptive three-line chroma comb: configuration registers,
// front end, operand queue and back end. Depends on atlcc_pkg and submodules.
//
//   channel   group                      dir  content
//   input     s_tvalid/s_tready/s_tdata  in   composite sample, tuser flags
//   output    m_tvalid/m_tready/m_tdata  out  2D chroma, tlast on last column
//   config    cfg_we/cfg_index/cfg_data  in   register writes
//
// Inputs enter at one per cycle while the four-entry queue has room.
// Each result holds the back end for eleven fixed steps plus an 18-step
// division for each of the two weights and the normaliser that needs one.
// Items that give no result never reach the back end. Reset is synchronous;
// the line stores need no clearing pass and are undefined until written.
module adaptive_three_line_chroma_comb_core import atlcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] sample
  input  logic [1:0]             s_tuser,   // [0] line_start, [1] line_active
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [17:0] chroma, rest zero
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_COL_W-1:0] active_start;
  logic [CFG_COL_W-1:0] active_end;
  logic [KR_W-1:0]      k_range;

  logic                 push;
  opnd_t                push_data;
  logic                 pop;
  opnd_t                pop_data;
  logic                 fifo_empty;
  logic [FIFO_CW-1:0]   fifo_count;
  logic signed [CHROMA_W-1:0] chroma;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_start <= ACTIVE_START_RST;
      active_end   <= ACTIVE_END_RST;
      k_range      <= K_RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_START: active_start <= cfg_data[CFG_COL_W-1:0];
        REG_ACTIVE_END:   active_end   <= cfg_data[CFG_COL_W-1:0];
        REG_K_RANGE:      k_range      <= cfg_data[KR_W-1:0];
        default: ;
      endcase
    end
  end

  atlcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample       (s_tdata[SAMPLE_W-1:0]),
    .line_start   (s_tuser[0]),
    .line_active  (s_tuser[1]),
    .active_start (active_start),
    .active_end   (active_end),
    .fifo_count   (fifo_count),
    .push         (push),
    .push_data    (push_data)
  );

  atlcc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty),
    .count     (fifo_count)
  );

  atlcc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .fifo_data  (pop_data),
    .pop        (pop),
    .k_range    (k_range),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .chroma     (chroma),
    .last       (m_tlast)
  );

  assign m_tdata = {{(TDATA_OUT_W - CHROMA_W){1'b0}}, chroma};

endmodule
